@@ src/bttd_pkg.sv @@
// Shared types, constants and the glyph table for the base-40 triplet decoder.
`timescale 1ns / 1ps

package bttd_pkg;

   // Digit and word limits
   localparam int unsigned DIGIT_W = 6;
   localparam logic [DIGIT_W-1:0] SHIFT_DIGIT = 6'd39;
   localparam logic [15:0] WORD_LIMIT = 16'd63999;

   // Reciprocals for the constant divides (x/25 on 10 bits, x/5 on 8 bits)
   localparam logic [20:0] RECIP_25 = 21'd1311;
   localparam int unsigned RECIP_25_SHIFT = 15;
   localparam logic [15:0] RECIP_5 = 16'd205;
   localparam int unsigned RECIP_5_SHIFT = 10;

   // One classified word as it travels from front to back
   typedef struct packed {
      logic bad;
      logic [DIGIT_W-1:0] d0;
      logic [DIGIT_W-1:0] d1;
      logic [DIGIT_W-1:0] d2;
   } entry_type;

   // Lower-case row
   function automatic logic [6:0] lower_glyph(input logic [DIGIT_W-1:0] digit);
      logic [6:0] code;
      case (digit) inside
         [6'd1:6'd26]:  code = 7'h60 + {1'b0, digit};
         [6'd27:6'd36]: code = 7'd21 + {1'b0, digit};
         6'd37:         code = 7'h20;
         6'd38:         code = 7'd10;
         default:       code = 7'd0;
      endcase
      return code;
   endfunction

   // Upper-case and symbol row
   function automatic logic [6:0] upper_glyph(input logic [DIGIT_W-1:0] digit);
      logic [6:0] code;
      case (digit) inside
         [6'd1:6'd26]: code = 7'h40 + {1'b0, digit};
         6'd27:        code = 7'h28;
         6'd28:        code = 7'h21;
         6'd29:        code = 7'h40;
         6'd30:        code = 7'h23;
         6'd31:        code = 7'h2C;
         6'd32:        code = 7'h2E;
         6'd33:        code = 7'h3F;
         6'd34:        code = 7'h2F;
         6'd35:        code = 7'h2A;
         6'd36:        code = 7'h29;
         6'd37:        code = 7'h3C;
         6'd38:        code = 7'h3E;
         default:      code = 7'd0;
      endcase
      return code;
   endfunction

   function automatic logic [6:0] glyph(input logic upper, input logic [DIGIT_W-1:0] digit);
      return upper ? upper_glyph(digit) : lower_glyph(digit);
   endfunction

endpackage

@@ src/bttd_front.sv @@
// Front end: accepts packed words and splits them into three base-40 digits.
`timescale 1ns / 1ps

module bttd_front
   import bttd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   input  logic [15:0] req_tdata,
   output logic      push_valid,
   input  logic      push_ready,
   output entry_type push_data
);

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_bad_ff, s1_bad_in;
   logic [DIGIT_W-1:0] s1_d0_ff, s1_d0_in;
   logic [10:0]       s1_rem_ff, s1_rem_in;

   logic [20:0] q0_prod;
   logic [15:0] d0_x1600;
   logic [15:0] rem_full;
   logic [15:0] q1_prod;
   logic [DIGIT_W-1:0] d1;
   logic [10:0] d1_x40;
   logic [10:0] d2_full;
   logic        req_fire;

   assign req_tready = !s1_valid_ff || push_ready;
   assign req_fire   = req_tvalid && req_tready;

   // Stage 1: top digit by reciprocal multiply, then the remainder below 1600
   always_comb begin
      q0_prod   = {11'd0, req_tdata[15:6]} * RECIP_25;
      s1_d0_in  = q0_prod[RECIP_25_SHIFT +: DIGIT_W];
      d0_x1600  = ({10'd0, s1_d0_in} << 10) + ({10'd0, s1_d0_in} << 9)
                + ({10'd0, s1_d0_in} << 6);
      rem_full  = req_tdata - d0_x1600;
      s1_rem_in = rem_full[10:0];
      s1_bad_in = req_tdata > WORD_LIMIT;
   end

   // Hold stage 1 while the queue is full
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_bad_ff <= s1_bad_in;
         s1_d0_ff  <= s1_d0_in;
         s1_rem_ff <= s1_rem_in;
      end
   end

   // Stage 2: middle and low digits from the remainder
   always_comb begin
      q1_prod = {8'd0, s1_rem_ff[10:3]} * RECIP_5;
      d1      = q1_prod[RECIP_5_SHIFT +: DIGIT_W];
      d1_x40  = ({5'd0, d1} << 5) + ({5'd0, d1} << 3);
      d2_full = s1_rem_ff - d1_x40;
      push_data.bad = s1_bad_ff;
      push_data.d0  = s1_d0_ff;
      push_data.d1  = d1;
      push_data.d2  = d2_full[DIGIT_W-1:0];
   end

   assign push_valid = s1_valid_ff;

`ifndef SYNTHESIS
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !push_ready |=> s1_valid_ff && $stable(s1_d0_ff) && $stable(s1_rem_ff))
      else $error("front stage changed while stalled");
`endif

endmodule

@@ src/bttd_fifo.sv @@
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module bttd_fifo
   import bttd_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             in_fire, out_fire;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = out_valid && out_ready;

   // Advance pointers with explicit wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (in_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (out_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (in_fire && !out_fire) begin
         count_in = count_ff + 1'b1;
      end else if (out_fire && !in_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (in_fire) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef SYNTHESIS
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      in_fire && !out_fire |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill level lost a transfer");
`endif

endmodule

@@ src/bttd_back.sv @@
// Back end: walks the digits of each word, tracks shift, emits characters.
`timescale 1ns / 1ps

module bttd_back
   import bttd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   output logic      head_pop,
   input  entry_type head_data,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic      rsp_tlast,
   output logic      rsp_tuser
);

   typedef enum logic [1:0] {
      POS_HI,
      POS_MID,
      POS_LO
   } pos_type;

   pos_type      pos_ff, pos_in;
   logic         shift_ff, shift_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [6:0]   rsp_char_ff, rsp_char_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         rsp_bad_ff, rsp_bad_in;

   logic               step;
   logic [DIGIT_W-1:0] digit;
   logic               rest_shift;
   logic               emit;

   assign step = head_valid && (!rsp_valid_ff || rsp_tready);

   // Select the current digit and whether only shifts follow it
   always_comb begin
      unique case (pos_ff)
         POS_HI: begin
            digit      = head_data.d0;
            rest_shift = (head_data.d1 == SHIFT_DIGIT) && (head_data.d2 == SHIFT_DIGIT);
         end
         POS_MID: begin
            digit      = head_data.d1;
            rest_shift = head_data.d2 == SHIFT_DIGIT;
         end
         POS_LO: begin
            digit      = head_data.d2;
            rest_shift = 1'b1;
         end
         default: begin
            digit      = head_data.d2;
            rest_shift = 1'b1;
         end
      endcase
   end

   assign emit = step && (head_data.bad || digit != SHIFT_DIGIT);

   // Step one digit per cycle while the result is not stalled; a bad word takes a single step
   always_comb begin
      pos_in       = pos_ff;
      shift_in     = shift_ff;
      head_pop     = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
      if (step) begin
         if (head_data.bad) begin
            rsp_char_in = 7'd0;
            rsp_last_in = 1'b1;
            rsp_bad_in  = 1'b1;
            head_pop    = 1'b1;
            pos_in      = POS_HI;
         end else begin
            if (digit == SHIFT_DIGIT) begin
               shift_in = 1'b1;
            end else begin
               rsp_char_in = glyph(shift_ff, digit);
               rsp_last_in = rest_shift;
               rsp_bad_in  = 1'b0;
               shift_in    = 1'b0;
            end
            unique case (pos_ff)
               POS_HI:  pos_in = POS_MID;
               POS_MID: pos_in = POS_LO;
               POS_LO: begin
                  pos_in   = POS_HI;
                  head_pop = 1'b1;
               end
               default: begin
                  pos_in   = POS_HI;
                  head_pop = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HI;
         shift_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

`ifndef SYNTHESIS
   a_bad_keeps_shift: assert property (@(posedge clock) disable iff (reset)
      step && head_data.bad |=> shift_ff == $past(shift_ff))
      else $error("bad word changed the shift flag");

   a_bad_at_word_start: assert property (@(posedge clock) disable iff (reset)
      step && head_data.bad |-> pos_ff == POS_HI)
      else $error("bad word seen mid-word");

   a_bad_result_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_last_ff && rsp_char_ff == 7'd0)
      else $error("bad-word result not marked last with zero code");
`endif

endmodule

@@ src/base40_triplet_text_decoder.sv @@
// Top level of the base-40 triplet text decoder: front, queue and back.
//
//   channel  dir  tdata (low bit up)          tlast          tuser
//   req_     in   packed_word[15:0]           -              -
//   rsp_     out  char_code[6:0], pad zero    last_of_word   bad_word
//
// The back end steps one digit per cycle while the result is not stalled,
// so a valid word takes three steps and a word above 63999 takes one. A
// word's first character appears once any leading shift digits are passed.
// Synchronous reset clears the queue, the shift flag and both valid
// stages. Either side may stall: the queue lets the front keep taking
// words while the result register waits.
`timescale 1ns / 1ps

module base40_triplet_text_decoder
   import bttd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [15:0] req_tdata,   // packed_word[15:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // char_code[6:0], bit 7 zero
   output logic       rsp_tlast,
   output logic       rsp_tuser     // bad_word
);

   logic      push_valid, push_ready;
   entry_type push_data;
   logic      head_valid, head_pop;
   entry_type head_data;

   bttd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bttd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (head_valid),
      .out_ready (head_pop),
      .out_data  (head_data)
   );

   bttd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_data  (head_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
